// ===== rtl/core/met_pkg.sv =====
// met_pkg: shared types, register codes, reset values and helpers for the
// mandelbrot escape-time unit. No dependencies.

package met_pkg;

  // register map
  localparam int REG_ADDR_W = 5;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    REG_MAX_ITER   = 3'd0,
    REG_REAL_START = 3'd1,
    REG_IMAG_START = 3'd2,
    REG_REAL_STEP  = 3'd3,
    REG_IMAG_STEP  = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [15:0] RST_MAX_ITER   = 16'd500;
  localparam logic [31:0] RST_REAL_START = 32'hE000_0000;  // -2.0 in Q4.28
  localparam logic [31:0] RST_IMAG_START = 32'hE000_0000;
  localparam logic [30:0] RST_REAL_STEP  = 31'd205698;
  localparam logic [30:0] RST_IMAG_STEP  = 31'd360316;

  localparam logic [23:0] COLOR_FACTOR = 24'hF0F8FF;

  typedef struct packed {
    logic [15:0] max_iter;
    logic [31:0] re_origin;
    logic [31:0] im_origin;
    logic [30:0] real_step;
    logic [30:0] imag_step;
  } cfg_regs_t;

  // one mapped point c, both parts signed fixed point
  typedef struct packed {
    logic [31:0] c_re;
    logic [31:0] c_im;
  } point_t;

  // clamp a signed 64-bit value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/mandelbrot_escape_time_unit.sv =====
// Mandelbrot escape-time unit: one pixel request in, count, inside flag and color out.
// The engine works on one pixel at a time: it pops the next point only when idle, once
// the result register has taken the last result, which can wait on out_tready. Each pass
// is a multiply step (three 32x32 products) and an update/escape step of the shared loop.
// Mapping of the next pixel overlaps the current one through a two-entry queue.
// Reset (synchronous, rst_n low) empties all stages and loads register defaults.

module mandelbrot_escape_time_unit
  import met_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,    // [15:0] pixel_col, [31:16] pixel_row
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [47:0]           out_tdata,   // [15:0] iteration_count, [47:16] pixel_color
  output logic                  out_tuser,   // [0] inside_set
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [REG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  cfg_regs_t regs;
  logic      q_push;
  logic      q_ready;
  point_t    q_in;
  logic      q_valid;
  logic      q_pop;
  point_t    q_out;

  // configuration registers
  met_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  // pixel to point mapping
  met_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .regs      (regs),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_data    (q_in)
  );

  // point queue
  met_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  // iteration engine
  met_iter #(
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_out),
    .max_iter   (regs.max_iter),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/met_cfg.sv =====
// met_cfg: APB-style register file for the escape-time unit.
// Depends on met_pkg.

module met_cfg
  import met_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [REG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[REG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign regs       = regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.max_iter  <= RST_MAX_ITER;
      regs_r.re_origin <= RST_REAL_START;
      regs_r.im_origin <= RST_IMAG_START;
      regs_r.real_step <= RST_REAL_STEP;
      regs_r.imag_step <= RST_IMAG_STEP;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_ITER:   regs_r.max_iter  <= cfg_pwdata[15:0];
        REG_REAL_START: regs_r.re_origin <= cfg_pwdata;
        REG_IMAG_START: regs_r.im_origin <= cfg_pwdata;
        REG_REAL_STEP:  regs_r.real_step <= cfg_pwdata[30:0];
        REG_IMAG_STEP:  regs_r.imag_step <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_MAX_ITER:   cfg_prdata = {16'd0, regs_r.max_iter};
      REG_REAL_START: cfg_prdata = regs_r.re_origin;
      REG_IMAG_START: cfg_prdata = regs_r.im_origin;
      REG_REAL_STEP:  cfg_prdata = {1'b0, regs_r.real_step};
      REG_IMAG_STEP:  cfg_prdata = {1'b0, regs_r.imag_step};
      default:        cfg_prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/met_front.sv =====
// met_front: accepts pixel requests and maps them to points of the plane.
// Two stages: coordinate times step, then start offset and clamp. Depends on met_pkg.

module met_front
  import met_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] pixel_col, [31:16] pixel_row
  input  cfg_regs_t   regs,
  output logic        q_push,
  input  logic        q_ready,
  output point_t      q_data
);

  localparam int PW = COORD_WIDTH + 31;

  logic          s1_v_r;
  logic [PW-1:0] prod_re_r;
  logic [PW-1:0] prod_im_r;
  logic          s2_v_r;
  point_t        pt_r;
  logic          s1_adv;
  logic          s2_load;
  logic [63:0]   sum_re;
  logic [63:0]   sum_im;

  assign q_push    = s2_v_r & q_ready;
  assign s2_load   = s1_v_r & (~s2_v_r | q_push);
  assign in_tready = ~s1_v_r | s2_load;
  assign s1_adv    = in_tvalid & in_tready;
  assign q_data    = pt_r;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= 1'b1;
      end else if (s2_load) begin
        s1_v_r <= 1'b0;
      end
      if (s2_load) begin
        s2_v_r <= 1'b1;
      end else if (q_push) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  // stage one: coordinate times step
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prod_re_r <= PW'(in_tdata[COORD_WIDTH-1:0]) * PW'(regs.real_step);
      prod_im_r <= PW'(in_tdata[16 +: COORD_WIDTH]) * PW'(regs.imag_step);
    end
  end

  // stage two: add start and clamp
  assign sum_re = {{32{regs.re_origin[31]}}, regs.re_origin} + 64'(prod_re_r);
  assign sum_im = {{32{regs.im_origin[31]}}, regs.im_origin} + 64'(prod_im_r);

  always_ff @(posedge clk) begin
    if (s2_load) begin
      pt_r.c_re <= sat32($signed(sum_re));
      pt_r.c_im <= sat32($signed(sum_im));
    end
  end

endmodule

// ===== rtl/core/met_queue.sv =====
// met_queue: short point queue between the mapping front and the iteration engine.
// Depends on met_pkg.

module met_queue
  import met_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  output logic   push_ready,
  input  point_t push_data,
  output logic   pop_valid,
  input  logic   pop,
  output point_t pop_data
);

  point_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/met_iter.sv =====
// met_iter: iteration engine, z = z*z + c with escape test, plus result register.
// Three multipliers in one stage, update and escape test in the next. Depends on met_pkg.

module met_iter
  import met_pkg::*;
#(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  point_t      q_data,
  input  logic [15:0] max_iter,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] iteration_count, [47:16] pixel_color
  output logic        out_tuser   // [0] inside_set
);

  localparam int          ESC_SH    = 2 * FRAC_BITS + 2;
  localparam bit          ESC_ON    = (ESC_SH < 64);
  localparam logic [63:0] ESC_BOUND = ESC_ON ? (64'd1 << ESC_SH) : 64'd0;
  localparam logic [63:0] RE_BIAS   = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic [63:0] IM_BIAS   = (64'd1 << (FRAC_BITS - 1)) - 64'd1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [31:0] c_re_r, c_im_r;
  logic signed [31:0] z_re_r, z_im_r;
  logic [15:0]        count_r;
  logic signed [63:0] p_rr_r, p_ii_r, p_ri_r;
  logic               out_v_r;
  logic [15:0]        out_count_r;
  logic               out_inside_r;
  logic [31:0]        out_color_r;

  logic signed [63:0] sq;
  logic signed [63:0] sq_adj;
  logic signed [63:0] ri_adj;
  logic signed [63:0] re_q;
  logic signed [63:0] im_q;
  logic [31:0]        n_re;
  logic [31:0]        n_im;
  logic [63:0]        mag2;
  logic               esc_hit;
  logic               finish;
  logic               at_limit;
  logic [39:0]        color_prod;
  logic               out_load;

  // square-and-add update, truncating toward zero
  assign sq     = p_rr_r - p_ii_r;
  assign sq_adj = sq + (sq[63] ? $signed(RE_BIAS) : 64'sd0);
  assign ri_adj = p_ri_r + (p_ri_r[63] ? $signed(IM_BIAS) : 64'sd0);
  assign re_q   = sq_adj >>> FRAC_BITS;
  assign im_q   = ri_adj >>> (FRAC_BITS - 1);
  assign n_re   = sat32(re_q + 64'(c_re_r));
  assign n_im   = sat32(im_q + 64'(c_im_r));

  // escape test on the squares of the current z
  assign mag2    = p_rr_r + p_ii_r;
  assign esc_hit = ESC_ON && (count_r != 16'd0) && (mag2 > ESC_BOUND);
  assign finish  = esc_hit || (count_r >= max_iter);

  // result fields
  assign at_limit   = (count_r >= max_iter);
  assign color_prod = 40'(count_r) * 40'(COLOR_FACTOR);
  assign out_load   = (state_r == ST_DONE) && (!out_v_r || out_tready);
  assign q_pop      = (state_r == ST_IDLE) && q_valid;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = finish ? ST_DONE : ST_MUL;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // point, z, count and products
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          c_re_r  <= q_data.c_re;
          c_im_r  <= q_data.c_im;
          z_re_r  <= q_data.c_re;
          z_im_r  <= q_data.c_im;
          count_r <= 16'd0;
        end
      end
      ST_MUL: begin
        p_rr_r <= z_re_r * z_re_r;
        p_ii_r <= z_im_r * z_im_r;
        p_ri_r <= z_re_r * z_im_r;
      end
      ST_UPD: begin
        if (!finish) begin
          z_re_r  <= n_re;
          z_im_r  <= n_im;
          count_r <= count_r + 16'd1;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r  <= count_r;
      out_inside_r <= at_limit;
      out_color_r  <= at_limit ? 32'd0 : color_prod[31:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_color_r, out_count_r};
  assign out_tuser  = out_inside_r;

endmodule
